// ----- src/four_point_min_max_distance_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the four point min/max distance core
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef FOUR_POINT_MIN_MAX_DISTANCE_CORE_MACROS_SVH
`define FOUR_POINT_MIN_MAX_DISTANCE_CORE_MACROS_SVH

// Checked only outside reset
`define FPMMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define FPMMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fpmmd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpmmd_pkg
// Shared constants and tables for the four point min/max distance core.
// ----------------------------------------------------------------------------
`default_nettype none

package fpmmd_pkg;

  typedef logic [1:0] point_idx_t;

  localparam int POINTS = 4;
  localparam int AXES   = 3;
  localparam int PAIRS  = 6;
  localparam int FIELDS = POINTS * AXES;

  // Result fields are fixed at 25 bits
  localparam int OUT_BITS     = 25;
  localparam int M_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;
  localparam int M_PAD_BITS   = M_TDATA_BITS - 2 * OUT_BITS;

  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  // The six point pairs, in the order they are formed
  localparam point_idx_t PAIR_A [PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam point_idx_t PAIR_B [PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

`default_nettype wire

// ----- src/fpmmd_dist.sv -----
// ----------------------------------------------------------------------------
// fpmmd_dist
// Five-stage pipeline: axis differences, squares, pair sums, then min and max
// of the six squared distances.
// ----------------------------------------------------------------------------
`default_nettype none

module fpmmd_dist
  import fpmmd_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [FIELDS*COORD_BITS-1:0]      coords,
  output logic                              out_valid,
  output logic [2*COORD_BITS+1:0]           d2_min,
  output logic [2*COORD_BITS+1:0]           d2_max
);

  localparam int C      = COORD_BITS;
  localparam int SQ_W   = 2 * C;
  localparam int D2_W   = 2 * C + 2;
  localparam int STAGES = 5;

  logic [STAGES-1:0] vld;

  logic [C-1:0]    ad [PAIRS][AXES];
  logic [SQ_W-1:0] sq [PAIRS][AXES];
  logic [D2_W-1:0] d2 [PAIRS];
  logic [D2_W-1:0] lo1 [3];
  logic [D2_W-1:0] hi1 [3];
  logic [D2_W-1:0] lo2;
  logic [D2_W-1:0] hi2;
  logic [D2_W-1:0] lo2_next;
  logic [D2_W-1:0] hi2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    for (genvar k = 0; k < AXES; k++) begin : g_axis
      localparam int IA = (int'(PAIR_A[p]) * AXES + k) * C;
      localparam int IB = (int'(PAIR_B[p]) * AXES + k) * C;
      logic signed [C:0] ea;
      logic signed [C:0] eb;
      logic signed [C:0] df;
      logic [C-1:0]      mag_next;

      assign ea = {coords[IA+C-1], coords[IA +: C]};
      assign eb = {coords[IB+C-1], coords[IB +: C]};
      assign df = ea - eb;
      // magnitude never exceeds 2^C - 1, so C bits hold it
      assign mag_next = df[C] ? C'(-df) : df[C-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          ad[p][k] <= mag_next;
          sq[p][k] <= SQ_W'(ad[p][k]) * SQ_W'(ad[p][k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2[p] <= D2_W'(sq[p][0]) + D2_W'(sq[p][1]) + D2_W'(sq[p][2]);
      end
    end
  end

  for (genvar q = 0; q < 3; q++) begin : g_mm
    always_ff @(posedge clk) begin
      if (en) begin
        if (d2[2*q] < d2[2*q+1]) begin
          lo1[q] <= d2[2*q];
          hi1[q] <= d2[2*q+1];
        end else begin
          lo1[q] <= d2[2*q+1];
          hi1[q] <= d2[2*q];
        end
      end
    end
  end

  always_comb begin
    lo2_next = (lo1[0] < lo1[1]) ? lo1[0] : lo1[1];
    if (lo1[2] < lo2_next) lo2_next = lo1[2];
    hi2_next = (hi1[0] > hi1[1]) ? hi1[0] : hi1[1];
    if (hi1[2] > hi2_next) hi2_next = hi1[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo2 <= lo2_next;
      hi2 <= hi2_next;
    end
  end

  assign out_valid = vld[STAGES-1];
  assign d2_min    = lo2;
  assign d2_max    = hi2;

endmodule

`default_nettype wire

// ----- src/fpmmd_root.sv -----
// ----------------------------------------------------------------------------
// fpmmd_root
// Two-lane pipelined restoring square root, one result bit per stage,
// giving floor(sqrt(d2) * 2^FRAC_BITS).
// ----------------------------------------------------------------------------
`default_nettype none

module fpmmd_root #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2*COORD_BITS+1:0]             d2_a,
  input  logic [2*COORD_BITS+1:0]             d2_b,
  output logic                                out_valid,
  output logic [COORD_BITS+FRAC_BITS:0]       root_a,
  output logic [COORD_BITS+FRAC_BITS:0]       root_b
);

  localparam int D2_W  = 2 * COORD_BITS + 2;
  localparam int RB    = COORD_BITS + 1 + FRAC_BITS;
  localparam int RAD_W = 2 * RB;
  localparam int REM_W = RB + 2;
  localparam int LANES = 2;

  logic [RB:0]       vld;
  logic [RAD_W-1:0]  rad  [LANES][RB];
  logic [REM_W-1:0]  rem  [LANES][1:RB];
  logic [RB-1:0]     root [LANES][1:RB];
  logic [D2_W-1:0]   d2_in [LANES];

  assign d2_in[0] = d2_a;
  assign d2_in[1] = d2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RB-1:0], in_valid};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // scale by 4^FRAC_BITS so the root carries the fraction bits
    always_ff @(posedge clk) begin
      if (en) rad[l][0] <= RAD_W'(d2_in[l]) << (2 * FRAC_BITS);
    end

    for (genvar s = 0; s < RB; s++) begin : g_step
      logic [REM_W-1:0] rem_in;
      logic [RB-1:0]    root_in;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      logic             take;

      if (s == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_later
        assign rem_in  = rem[l][s];
        assign root_in = root[l][s];
      end

      assign rem2  = {rem_in[REM_W-3:0], rad[l][s][RAD_W-1 -: 2]};
      assign trial = {root_in, 2'b01};
      assign take  = (rem2 >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][s+1]  <= take ? (rem2 - trial) : rem2;
          root[l][s+1] <= {root_in[RB-2:0], take};
        end
      end

      if (s < RB - 1) begin : g_shift
        always_ff @(posedge clk) begin
          if (en) rad[l][s+1] <= {rad[l][s][RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = vld[RB];
  assign root_a    = root[0][RB];
  assign root_b    = root[1][RB];

endmodule

`default_nettype wire

// ----- src/four_point_min_max_distance_core.sv -----
// ----------------------------------------------------------------------------
// four_point_min_max_distance_core
// Minimum and maximum pairwise distance of four 3D points, fixed point out.
// ----------------------------------------------------------------------------
//  channel  dir  signals                    contents
//  s_       in   s_tvalid s_tready s_tdata  twelve coordinates
//  m_       out  m_tvalid m_tready m_tdata  min_distance, max_distance
//
//  One transfer in per cycle when m_tready stays high. Pipeline: five distance
//  stages, one radicand stage, one square root stage per result bit, one
//  output stage.
//  rst clears all valid bits and the skid entry; no clearing pass follows.
//  A stall at m_ fills the skid entry, which drops s_tready and freezes the
//  pipeline until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_point_min_max_distance_core_macros.svh"

module four_point_min_max_distance_core
  import fpmmd_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // p1_x, p1_y, p1_z, p2_x, ..., p4_z, COORD_BITS each, then zero fill
  input  logic [((FIELDS*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // min_distance[24:0], max_distance[49:25], zero fill
  output logic [M_TDATA_BITS-1:0]                   m_tdata
);

  localparam int D2_W   = 2 * COORD_BITS + 2;
  localparam int RB     = COORD_BITS + 1 + FRAC_BITS;
  localparam int WIDE_W = RB + OUT_BITS;

  function automatic logic [OUT_BITS-1:0] saturate(input logic [RB-1:0] r);
    logic [WIDE_W-1:0] r_ext;
    r_ext = WIDE_W'(r);
    return (r_ext > WIDE_W'(OUT_MAX)) ? OUT_MAX : r_ext[OUT_BITS-1:0];
  endfunction

  logic              en;
  logic              dist_valid;
  logic [D2_W-1:0]   d2_min;
  logic [D2_W-1:0]   d2_max;
  logic              root_valid;
  logic [RB-1:0]     root_min;
  logic [RB-1:0]     root_max;
  logic              push;

  logic                out_valid;
  logic [OUT_BITS-1:0] out_min;
  logic [OUT_BITS-1:0] out_max;
  logic                skid_valid;
  logic [OUT_BITS-1:0] skid_min;
  logic [OUT_BITS-1:0] skid_max;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign push     = en && root_valid;

  fpmmd_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .coords    (s_tdata[FIELDS*COORD_BITS-1:0]),
    .out_valid (dist_valid),
    .d2_min    (d2_min),
    .d2_max    (d2_max)
  );

  fpmmd_root #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dist_valid),
    .d2_a      (d2_min),
    .d2_b      (d2_max),
    .out_valid (root_valid),
    .root_a    (root_min),
    .root_b    (root_max)
  );

  // Output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !m_tready) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_min <= skid_min;
        out_max <= skid_max;
      end
    end else if (push) begin
      if (out_valid && !m_tready) begin
        skid_min <= saturate(root_min);
        skid_max <= saturate(root_max);
      end else begin
        out_min <= saturate(root_min);
        out_max <= saturate(root_max);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{M_PAD_BITS{1'b0}}, out_max, out_min};

  `FPMMD_ASSERT(a_skid_needs_out, skid_valid |-> out_valid, "skid entry held with no output")
  `FPMMD_ASSERT(a_min_le_max, out_valid |-> (out_min <= out_max), "min distance above max")
  `FPMMD_ASSERT(a_stall_fills_skid, (push && out_valid && !m_tready) |=> skid_valid, "transfer lost on stall")
  `FPMMD_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !skid_valid), "reset left output valid")

endmodule

`default_nettype wire
